[hw/rtl/sbc_pkg.sv]
package sbc_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int MAX_SUBDIV_DEF  = 64;

   localparam int CORDIC_STEPS = 16;
   localparam int PRESCALE_SH  = 8;
   localparam int GAIN_Q16     = 107922;
   localparam int GAIN_W       = 18;
   localparam int PI_Q16       = 205887;
   localparam int HALF_PI_Q16  = 102944;
   localparam int TWO_PI_Q16   = 411775;

   // signed angle accumulator and unsigned final angle widths
   localparam int ANGLE_W = 20;
   localparam int ANG_W   = 19;

   // reciprocal shift for the constant divisions in the binning
   localparam int RECIP_SH = 40;

   localparam int SUBDIV_W = 7;
   localparam logic [SUBDIV_W-1:0] SUBDIV_RESET = 7'd16;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBDIV   = 2'd3;

   localparam int AZ_W  = 6;
   localparam int INC_W = 6;
   localparam int IDX_W = 12;

   localparam int ATAN_Q16 [CORDIC_STEPS] = '{
      51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

endpackage

[hw/rtl/sbc_req_if.sv]
interface sbc_req_if #(parameter int W = sbc_pkg::COORD_WIDTH_DEF);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] point_x;
   logic signed [W-1:0] point_y;
   logic signed [W-1:0] point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface

[hw/rtl/sbc_rsp_if.sv]
interface sbc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sbc_pkg::AZ_W-1:0]    bucket_azimuth;
   logic [sbc_pkg::INC_W-1:0]   bucket_inclination;
   logic [sbc_pkg::IDX_W-1:0]   bucket_index;
   logic                        at_center;

   modport source (output valid, output bucket_azimuth, output bucket_inclination,
                   output bucket_index, output at_center, input ready);
   modport sink   (input valid, input bucket_azimuth, input bucket_inclination,
                   input bucket_index, input at_center, output ready);
endinterface

[hw/rtl/sbc_cordic_step.sv]
module sbc_cordic_step #(
   parameter int W     = 38,
   parameter int SHIFT = 0,
   parameter int ATAN  = 0,
   parameter int SBW   = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 src_valid,
   input  logic signed [W-1:0]                  src_x,
   input  logic signed [W-1:0]                  src_y,
   input  logic signed [sbc_pkg::ANGLE_W-1:0]   src_z,
   input  logic [SBW-1:0]                       src_side,
   output logic                                 dst_valid,
   output logic signed [W-1:0]                  dst_x,
   output logic signed [W-1:0]                  dst_y,
   output logic signed [sbc_pkg::ANGLE_W-1:0]   dst_z,
   output logic [SBW-1:0]                       dst_side
);
   import sbc_pkg::*;

   localparam logic signed [ANGLE_W-1:0] STEP_ANGLE = ANGLE_W'(ATAN);

   logic                      valid_ff;
   logic signed [W-1:0]       x_ff, x_in;
   logic signed [W-1:0]       y_ff, y_in;
   logic signed [ANGLE_W-1:0] z_ff, z_in;
   logic [SBW-1:0]            side_ff;
   logic signed [W-1:0]       xs, ys;

   always_comb begin
      xs = src_x >>> SHIFT;
      ys = src_y >>> SHIFT;
      if (!src_y[W-1]) begin
         x_in = src_x + ys;
         y_in = src_y - xs;
         z_in = src_z + STEP_ANGLE;
      end else begin
         x_in = src_x - ys;
         y_in = src_y + xs;
         z_in = src_z - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= src_side;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_x     = x_ff;
   assign dst_y     = y_ff;
   assign dst_z     = z_ff;
   assign dst_side  = side_ff;

endmodule

[hw/rtl/sbc_bin_quant.sv]
// floor(angle*n/DIVISOR) clamped to n-1, three register stages
module sbc_bin_quant #(
   parameter int NW      = 7,
   parameter int BW      = 6,
   parameter int DIVISOR = 411775
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [sbc_pkg::ANG_W-1:0]   angle,
   input  logic [NW-1:0]               n,
   output logic [BW-1:0]               bin
);
   import sbc_pkg::*;

   localparam longint RECIP = (64'd1 << RECIP_SH) / DIVISOR;
   localparam int PW = ANG_W + NW;
   localparam int RW = $clog2(RECIP + 1);
   localparam int QW = NW + 2;
   localparam int MW = (PW + RW > RECIP_SH + QW) ? PW + RW : RECIP_SH + QW;

   logic [PW-1:0] p_ff, p_in;
   logic [PW-1:0] p2_ff;
   logic [MW-1:0] prod;
   logic [QW-1:0] q0_ff, q0_in;
   logic [PW-1:0] qc, rem;
   logic [QW-1:0] q, qn;
   logic [BW-1:0] bin_ff, bin_in;

   assign p_in = PW'(angle) * PW'(n);

   // reciprocal estimate is low by at most one
   always_comb begin
      prod  = MW'(p_ff) * MW'(RECIP);
      q0_in = prod[RECIP_SH +: QW];
   end

   always_comb begin
      qc  = PW'(q0_ff) * PW'(DIVISOR);
      rem = p2_ff - qc;
      q   = (rem >= PW'(DIVISOR)) ? q0_ff + QW'(1) : q0_ff;
      qn  = QW'(n) - QW'(1);
      bin_in = (q > qn) ? BW'(qn) : BW'(q);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= p_in;
         p2_ff  <= p_ff;
         q0_ff  <= q0_in;
         bin_ff <= bin_in;
      end
   end

   assign bin = bin_ff;

endmodule

[hw/rtl/spherical_bucket_classifier_core.sv]
// channel   dir  handshake        payload
// req_chan  in   valid/ready      point_x, point_y, point_z
// rsp_chan  out  valid/ready      bucket_azimuth, bucket_inclination, bucket_index, at_center
// csr       in   csr_we           csr_index, csr_wdata
//
// One beat per cycle while rsp_chan does not stall; stages: difference, prescale, 16 azimuth
// CORDIC stages, rotate, 16 inclination CORDIC stages, 3 binning stages, index.
// Synchronous reset clears valid bits, centers to zero and N to 16.
// A stall on rsp_chan freezes the whole pipeline and drops req_chan.ready.
module spherical_bucket_classifier_core #(
   parameter int COORD_WIDTH      = sbc_pkg::COORD_WIDTH_DEF,
   parameter int MAX_SUBDIVISIONS = sbc_pkg::MAX_SUBDIV_DEF,
   localparam int CSR_W = (COORD_WIDTH > sbc_pkg::SUBDIV_W) ? COORD_WIDTH : sbc_pkg::SUBDIV_W
) (
   input  logic                            clock,
   input  logic                            reset,
   sbc_req_if.sink                         req_chan,
   sbc_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [sbc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]                csr_wdata
);
   import sbc_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;
   localparam int XW  = CW + 14;
   localparam int NW  = $clog2(MAX_SUBDIVISIONS + 1);
   localparam int BW  = (MAX_SUBDIVISIONS > 1) ? $clog2(MAX_SUBDIVISIONS) : 1;
   localparam int GW  = DW + GAIN_W;
   localparam int SB1 = 2 + GW;
   localparam int SB2 = 1 + ANG_W;
   localparam int NB  = 3;
   localparam logic signed [GAIN_W-1:0]  GAIN_S    = GAIN_W'(GAIN_Q16);
   localparam logic signed [ANGLE_W-1:0] HALF_PI_S = ANGLE_W'(HALF_PI_Q16);
   localparam logic signed [ANGLE_W-1:0] TWO_PI_S  = ANGLE_W'(TWO_PI_Q16);

   // configuration
   logic [CW-1:0]       center_x_ff, center_y_ff, center_z_ff;
   logic [SUBDIV_W-1:0] subdiv_ff;
   logic [NW-1:0]       n_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         subdiv_ff   <= SUBDIV_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_wdata[CW-1:0];
            CSR_CENTER_Y: center_y_ff <= csr_wdata[CW-1:0];
            CSR_CENTER_Z: center_z_ff <= csr_wdata[CW-1:0];
            CSR_SUBDIV:   subdiv_ff   <= csr_wdata[SUBDIV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (subdiv_ff == '0) begin
         n_eff = NW'(1);
      end else if (32'(subdiv_ff) > 32'(MAX_SUBDIVISIONS)) begin
         n_eff = NW'(MAX_SUBDIVISIONS);
      end else begin
         n_eff = NW'(subdiv_ff);
      end
   end

   logic en;
   logic ix_valid_ff;

   assign en             = !ix_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // stage 0: differences
   logic                s0_valid_ff;
   logic signed [DW-1:0] s0_dx_ff, s0_dy_ff, s0_dz_ff;
   logic signed [DW-1:0] dx_in, dy_in, dz_in;
   logic                s0_cent_ff, s0_zaxis_ff;

   always_comb begin
      dx_in = DW'(req_chan.point_x) - DW'($signed(center_x_ff));
      dy_in = DW'(req_chan.point_y) - DW'($signed(center_y_ff));
      dz_in = DW'(req_chan.point_z) - DW'($signed(center_z_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_dx_ff    <= dx_in;
         s0_dy_ff    <= dy_in;
         s0_dz_ff    <= dz_in;
         s0_zaxis_ff <= (dx_in == '0) && (dy_in == '0);
         s0_cent_ff  <= (dx_in == '0) && (dy_in == '0) && (dz_in == '0);
      end
   end

   // stage 1: prescale, quadrant fold, dz gain product
   logic                      s1_valid_ff;
   logic signed [XW-1:0]      s1_x_ff, s1_y_ff, s1_x_in, s1_y_in, xp, yp;
   logic signed [ANGLE_W-1:0] s1_z_ff, s1_z_in;
   logic [SB1-1:0]            s1_side_ff;
   logic signed [GW-1:0]      dzp_in;

   always_comb begin
      xp = XW'(s0_dx_ff) <<< PRESCALE_SH;
      yp = XW'(s0_dy_ff) <<< PRESCALE_SH;
      s1_x_in = xp;
      s1_y_in = yp;
      s1_z_in = '0;
      if (xp[XW-1]) begin
         if (!yp[XW-1]) begin
            s1_x_in = yp;
            s1_y_in = -xp;
            s1_z_in = HALF_PI_S;
         end else begin
            s1_x_in = -yp;
            s1_y_in = xp;
            s1_z_in = -HALF_PI_S;
         end
      end
      dzp_in = GW'(s0_dz_ff) * GW'(GAIN_S);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff    <= s1_x_in;
         s1_y_ff    <= s1_y_in;
         s1_z_ff    <= s1_z_in;
         s1_side_ff <= {s0_cent_ff, s0_zaxis_ff, dzp_in};
      end
   end

   // azimuth CORDIC
   logic                      c1_valid [CORDIC_STEPS+1];
   logic signed [XW-1:0]      c1_x     [CORDIC_STEPS+1];
   logic signed [XW-1:0]      c1_y     [CORDIC_STEPS+1];
   logic signed [ANGLE_W-1:0] c1_z     [CORDIC_STEPS+1];
   logic [SB1-1:0]            c1_side  [CORDIC_STEPS+1];

   assign c1_valid[0] = s1_valid_ff;
   assign c1_x[0]     = s1_x_ff;
   assign c1_y[0]     = s1_y_ff;
   assign c1_z[0]     = s1_z_ff;
   assign c1_side[0]  = s1_side_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_az
      sbc_cordic_step #(.W(XW), .SHIFT(i), .ATAN(ATAN_Q16[i]), .SBW(SB1)) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .src_valid (c1_valid[i]),
         .src_x     (c1_x[i]),
         .src_y     (c1_y[i]),
         .src_z     (c1_z[i]),
         .src_side  (c1_side[i]),
         .dst_valid (c1_valid[i+1]),
         .dst_x     (c1_x[i+1]),
         .dst_y     (c1_y[i+1]),
         .dst_z     (c1_z[i+1]),
         .dst_side  (c1_side[i+1])
      );
   end

   // stage 2: wrap phi, set up (dz*K, rho)
   logic                      s2_valid_ff;
   logic signed [XW-1:0]      s2_x_ff, s2_y_ff, s2_x_in, s2_y_in, rho, dzk;
   logic signed [ANGLE_W-1:0] s2_z_ff, s2_z_in, phi_w;
   logic [SB2-1:0]            s2_side_ff;
   logic [ANG_W-1:0]          phi_u;
   logic signed [GW-1:0]      dzp, dzs;
   logic                      c1_cent, c1_zaxis;

   always_comb begin
      c1_cent  = c1_side[CORDIC_STEPS][SB1-1];
      c1_zaxis = c1_side[CORDIC_STEPS][SB1-2];
      dzp      = c1_side[CORDIC_STEPS][GW-1:0];
      dzs      = dzp >>> PRESCALE_SH;
      dzk      = dzs[XW-1:0];
      phi_w    = c1_z[CORDIC_STEPS];
      if (phi_w[ANGLE_W-1]) begin
         phi_w = phi_w + TWO_PI_S;
      end
      if (phi_w[ANGLE_W-1] || c1_zaxis) begin
         phi_w = '0;
      end
      phi_u = phi_w[ANG_W-1:0];
      rho   = c1_zaxis ? '0 : c1_x[CORDIC_STEPS];
      s2_x_in = dzk;
      s2_y_in = rho;
      s2_z_in = '0;
      if (dzk[XW-1]) begin
         if (!rho[XW-1]) begin
            s2_x_in = rho;
            s2_y_in = -dzk;
            s2_z_in = HALF_PI_S;
         end else begin
            s2_x_in = -rho;
            s2_y_in = dzk;
            s2_z_in = -HALF_PI_S;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= c1_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_x_ff    <= s2_x_in;
         s2_y_ff    <= s2_y_in;
         s2_z_ff    <= s2_z_in;
         s2_side_ff <= {c1_cent, phi_u};
      end
   end

   // inclination CORDIC
   logic                      c2_valid [CORDIC_STEPS+1];
   logic signed [XW-1:0]      c2_x     [CORDIC_STEPS+1];
   logic signed [XW-1:0]      c2_y     [CORDIC_STEPS+1];
   logic signed [ANGLE_W-1:0] c2_z     [CORDIC_STEPS+1];
   logic [SB2-1:0]            c2_side  [CORDIC_STEPS+1];

   assign c2_valid[0] = s2_valid_ff;
   assign c2_x[0]     = s2_x_ff;
   assign c2_y[0]     = s2_y_ff;
   assign c2_z[0]     = s2_z_ff;
   assign c2_side[0]  = s2_side_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_inc
      sbc_cordic_step #(.W(XW), .SHIFT(i), .ATAN(ATAN_Q16[i]), .SBW(SB2)) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .src_valid (c2_valid[i]),
         .src_x     (c2_x[i]),
         .src_y     (c2_y[i]),
         .src_z     (c2_z[i]),
         .src_side  (c2_side[i]),
         .dst_valid (c2_valid[i+1]),
         .dst_x     (c2_x[i+1]),
         .dst_y     (c2_y[i+1]),
         .dst_z     (c2_z[i+1]),
         .dst_side  (c2_side[i+1])
      );
   end

   // binning
   logic [ANG_W-1:0] theta_u, phi_b;
   logic [BW-1:0]    az_bin, inc_bin;
   logic             bq_valid_ff [NB];
   logic             bq_cent_ff  [NB];
   logic signed [ANGLE_W-1:0] theta_raw;

   always_comb begin
      theta_raw = c2_z[CORDIC_STEPS];
      theta_u   = theta_raw[ANGLE_W-1] ? '0 : theta_raw[ANG_W-1:0];
      phi_b     = c2_side[CORDIC_STEPS][ANG_W-1:0];
   end

   sbc_bin_quant #(.NW(NW), .BW(BW), .DIVISOR(TWO_PI_Q16)) u_az_bin (
      .clock (clock),
      .en    (en),
      .angle (phi_b),
      .n     (n_eff),
      .bin   (az_bin)
   );

   sbc_bin_quant #(.NW(NW), .BW(BW), .DIVISOR(PI_Q16)) u_inc_bin (
      .clock (clock),
      .en    (en),
      .angle (theta_u),
      .n     (n_eff),
      .bin   (inc_bin)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NB; k++) begin
            bq_valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         bq_valid_ff[0] <= c2_valid[CORDIC_STEPS];
         for (int k = 1; k < NB; k++) begin
            bq_valid_ff[k] <= bq_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bq_cent_ff[0] <= c2_side[CORDIC_STEPS][SB2-1];
         for (int k = 1; k < NB; k++) begin
            bq_cent_ff[k] <= bq_cent_ff[k-1];
         end
      end
   end

   // index stage, also the output register
   logic [BW-1:0]    az_ff, inc_ff, az_in, inc_in;
   logic [BW+NW-1:0] idx_ff, idx_in;
   logic             cent_ff;
   logic [31:0]      az32, inc32, idx32;

   always_comb begin
      az_in  = bq_cent_ff[NB-1] ? '0 : az_bin;
      inc_in = bq_cent_ff[NB-1] ? '0 : inc_bin;
      idx_in = (BW+NW)'(az_in) * (BW+NW)'(n_eff) + (BW+NW)'(inc_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ix_valid_ff <= 1'b0;
      end else if (en) begin
         ix_valid_ff <= bq_valid_ff[NB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         az_ff   <= az_in;
         inc_ff  <= inc_in;
         idx_ff  <= idx_in;
         cent_ff <= bq_cent_ff[NB-1];
      end
   end

   assign az32  = 32'(az_ff);
   assign inc32 = 32'(inc_ff);
   assign idx32 = 32'(idx_ff);

   assign rsp_chan.valid              = ix_valid_ff;
   assign rsp_chan.bucket_azimuth     = az32[AZ_W-1:0];
   assign rsp_chan.bucket_inclination = inc32[INC_W-1:0];
   assign rsp_chan.bucket_index       = idx32[IDX_W-1:0];
   assign rsp_chan.at_center          = cent_ff;

endmodule

[hw/rtl/sbc_checker.sv]
module sbc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sbc_pkg::AZ_W-1:0]      rsp_azimuth,
   input logic [sbc_pkg::INC_W-1:0]     rsp_inclination,
   input logic [sbc_pkg::IDX_W-1:0]     rsp_index,
   input logic                          rsp_at_center
);

   // a held beat stays up until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_center_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_center |->
         rsp_azimuth == '0 && rsp_inclination == '0 && rsp_index == '0)
      else $error("center point with nonzero bins");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("rsp beat right after reset");

   // pipeline only stalls on a held output
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

endmodule

bind spherical_bucket_classifier_core sbc_checker u_sbc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_azimuth     (rsp_chan.bucket_azimuth),
   .rsp_inclination (rsp_chan.bucket_inclination),
   .rsp_index       (rsp_chan.bucket_index),
   .rsp_at_center   (rsp_chan.at_center)
);
